// ===== rtl/rrm_pkg.sv =====
package rrm_pkg;

    localparam int CFG_W  = 13;
    localparam int CELL_W = 12;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_ROW_LENGTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] RST_ROW_LENGTH = 13'd1024;
    localparam logic [CFG_W-1:0] RST_GRID_SIZE  = 13'd1;
    localparam logic [CFG_W-1:0] GRID_MAX       = 13'd4096;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT,
        ST_EMIT
    } rrm_state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic div_step;
        logic root_step;
        logic emit;
    } rrm_cmd_t;

    typedef struct packed {
        logic row_done;
        logic would_last;
        logic out_free;
    } rrm_status_t;

endpackage

// ===== rtl/row_rms_meter.sv =====
// RMS level meter over rows of signed fixed-point samples. Each accepted sample
// is squared and summed; after row_length samples (register 0, reset 1024,
// 0 read as 1, capped at MAX_ROW_LENGTH) one result carries
// floor(sqrt(sum / row_length)) as unsigned Q1.15 plus the row's grid row and
// column in a grid_height (register 2) by grid_width (register 1) grid, row-major,
// wrapping after height*width rows. Samples are taken one per clock except
// when a row's last sample is held off. At each row end the sum goes to a
// single back end: a restoring divider giving one quotient bit per cycle, then
// a digit-by-digit square root giving one result bit per cycle, then the output
// register once that is free. A row's last sample is held off while the
// previous row is still in the back end or about to enter it, so the next
// row's other samples are taken while the back end works. The user must write
// configuration only while the block is idle; the block itself does not
// enforce this.
module row_rms_meter #(
    parameter int SAMPLE_BITS    = 16,
    parameter int MAX_ROW_LENGTH = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rrm_pkg::IDX_W-1:0]          cfg_index,
    input  logic [rrm_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [SAMPLE_BITS-1:0]             m_rms_level,
    output logic [rrm_pkg::CELL_W-1:0]         m_grid_row,
    output logic [rrm_pkg::CELL_W-1:0]         m_grid_col
);

    localparam int ACC_RAW    = 2 * SAMPLE_BITS - 2 + $clog2(MAX_ROW_LENGTH + 1);
    localparam int ACC_W      = (ACC_RAW > 64) ? 64 : ACC_RAW;
    localparam int ROOT_STEPS = (ACC_W + 1) / 2;

    rrm_pkg::rrm_cmd_t    cmd;
    rrm_pkg::rrm_status_t status;

    rrm_ctrl #(
        .DIV_STEPS  (ACC_W),
        .ROOT_STEPS (ROOT_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rrm_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .ACC_W          (ACC_W),
        .ROOT_STEPS     (ROOT_STEPS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rms_level (m_rms_level),
        .m_grid_row  (m_grid_row),
        .m_grid_col  (m_grid_col),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== rtl/rrm_ctrl.sv =====
module rrm_ctrl #(
    parameter int DIV_STEPS  = 43,
    parameter int ROOT_STEPS = 22
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rrm_pkg::rrm_status_t status,
    output rrm_pkg::rrm_cmd_t    cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    rrm_pkg::rrm_state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrm_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        // a row-ending sample waits until the back end can take its row
        s_ready    = !(status.would_last
                       && (state_reg != rrm_pkg::ST_IDLE || status.row_done));
        cmd.accept = s_valid && s_ready;
        case (state_reg)
            rrm_pkg::ST_IDLE: begin
                if (status.row_done) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = rrm_pkg::ST_DIV;
                end
            end
            rrm_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = rrm_pkg::ST_ROOT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rrm_pkg::ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = rrm_pkg::ST_EMIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rrm_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = rrm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrm_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_row_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        status.row_done |-> state_reg == rrm_pkg::ST_IDLE)
        else $error("row finished while back end busy");

    a_load_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        status.row_done |=> state_reg == rrm_pkg::ST_DIV && cnt_reg == '0)
        else $error("row end did not start divider");

    a_emit_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rrm_pkg::ST_EMIT
        |=> state_reg == rrm_pkg::ST_EMIT || state_reg == rrm_pkg::ST_IDLE)
        else $error("bad exit from emit");
`endif

endmodule

// ===== rtl/rrm_datapath.sv =====
module rrm_datapath #(
    parameter int SAMPLE_BITS    = 16,
    parameter int MAX_ROW_LENGTH = 4096,
    parameter int ACC_W          = 43,
    parameter int ROOT_STEPS     = 22
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rrm_pkg::IDX_W-1:0]      cfg_index,
    input  logic [rrm_pkg::CFG_W-1:0]      cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]  s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [SAMPLE_BITS-1:0]         m_rms_level,
    output logic [rrm_pkg::CELL_W-1:0]     m_grid_row,
    output logic [rrm_pkg::CELL_W-1:0]     m_grid_col,
    input  rrm_pkg::rrm_cmd_t              cmd,
    output rrm_pkg::rrm_status_t           status
);

    localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);
    localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
    localparam int QR_W  = 2 * ROOT_STEPS;
    localparam int RT_W  = ROOT_STEPS;
    localparam int RR_W  = ROOT_STEPS + 2;
    localparam int CW    = rrm_pkg::CFG_W;
    localparam int EW    = rrm_pkg::CELL_W;

    // configuration
    logic [CW-1:0] row_length_reg, grid_width_reg, grid_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg  <= rrm_pkg::RST_ROW_LENGTH;
            grid_width_reg  <= rrm_pkg::RST_GRID_SIZE;
            grid_height_reg <= rrm_pkg::RST_GRID_SIZE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rrm_pkg::REG_ROW_LENGTH:  row_length_reg  <= cfg_data;
                rrm_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                rrm_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0] len_eff;
    logic [CW-1:0]    w_eff, h_eff;

    always_comb begin
        if (row_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(row_length_reg) > 32'(MAX_ROW_LENGTH)) begin
            len_eff = LEN_W'(MAX_ROW_LENGTH);
        end else begin
            len_eff = LEN_W'(row_length_reg);
        end
        if (grid_width_reg == '0) begin
            w_eff = CW'(1);
        end else if (grid_width_reg > rrm_pkg::GRID_MAX) begin
            w_eff = rrm_pkg::GRID_MAX;
        end else begin
            w_eff = grid_width_reg;
        end
        if (grid_height_reg == '0) begin
            h_eff = CW'(1);
        end else if (grid_height_reg > rrm_pkg::GRID_MAX) begin
            h_eff = rrm_pkg::GRID_MAX;
        end else begin
            h_eff = grid_height_reg;
        end
    end

    // squaring stage and accumulator
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_W-1:0]        sq_reg;
    logic                   sq_valid_reg, sq_last_reg;
    logic [LEN_W-1:0]       seen_reg, seen_next;
    logic [LEN_W:0]         seen_inc;
    logic                   would_last;
    logic [ACC_W-1:0]       sum_reg, sum_next, sum_total;
    logic [ACC_W:0]         sum_wide;

    assign mag        = s_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s_sample) : s_sample;
    assign seen_inc   = {1'b0, seen_reg} + 1'b1;
    assign would_last = seen_inc >= {1'b0, len_eff};
    assign seen_next  = would_last ? '0 : seen_inc[LEN_W-1:0];

    assign sum_wide  = {1'b0, sum_reg} + (ACC_W + 1)'(sq_reg);
    assign sum_total = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];

    always_comb begin
        sum_next = sum_reg;
        if (sq_valid_reg) begin
            sum_next = sq_last_reg ? '0 : sum_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
            sq_last_reg  <= 1'b0;
            seen_reg     <= '0;
            sum_reg      <= '0;
        end else begin
            sq_valid_reg <= cmd.accept;
            if (cmd.accept) begin
                sq_last_reg <= would_last;
                seen_reg    <= seen_next;
            end
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sq_reg <= SQ_W'(mag * mag);
        end
    end

    // grid position
    logic [EW-1:0] cell_row_reg, cell_col_reg;
    logic [CW-1:0] col_inc, row_inc;

    assign col_inc = {1'b0, cell_col_reg} + 1'b1;
    assign row_inc = {1'b0, cell_row_reg} + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_row_reg <= '0;
            cell_col_reg <= '0;
        end else if (cmd.load) begin
            if (col_inc >= w_eff) begin
                cell_col_reg <= '0;
                cell_row_reg <= (row_inc >= h_eff) ? '0 : row_inc[EW-1:0];
            end else begin
                cell_col_reg <= col_inc[EW-1:0];
            end
        end
    end

    // shared divide then root back end
    logic [QR_W-1:0]  qr_reg, qr_next;
    logic [LEN_W-1:0] div_reg;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W:0]   rem_trial;
    logic             qbit;
    logic [RT_W-1:0]  root_reg, root_next;
    logic [RR_W-1:0]  rr_reg, rr_next;
    logic [RR_W+1:0]  rr_trial, rr_sub;
    logic [EW-1:0]    pos_row_reg, pos_col_reg;

    assign rem_trial = {rem_reg, qr_reg[ACC_W-1]};
    assign qbit      = rem_trial >= {1'b0, div_reg};
    assign rr_trial  = {rr_reg, qr_reg[QR_W-1 -: 2]};
    assign rr_sub    = (RR_W + 2)'({root_reg, 2'b01});

    always_comb begin
        qr_next   = qr_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rr_next   = rr_reg;
        if (cmd.load) begin
            qr_next   = QR_W'(sum_total);
            rem_next  = '0;
            root_next = '0;
            rr_next   = '0;
        end else if (cmd.div_step) begin
            qr_next  = QR_W'({qr_reg[ACC_W-2:0], qbit});
            rem_next = qbit ? LEN_W'(rem_trial - {1'b0, div_reg}) : LEN_W'(rem_trial);
        end else if (cmd.root_step) begin
            qr_next = qr_reg << 2;
            if (rr_trial >= rr_sub) begin
                rr_next   = RR_W'(rr_trial - rr_sub);
                root_next = {root_reg[RT_W-2:0], 1'b1};
            end else begin
                rr_next   = RR_W'(rr_trial);
                root_next = {root_reg[RT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        qr_reg   <= qr_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rr_reg   <= rr_next;
        if (cmd.load) begin
            div_reg     <= len_eff;
            pos_row_reg <= cell_row_reg;
            pos_col_reg <= cell_col_reg;
        end
    end

    // result register
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] rms_reg;
    logic [EW-1:0]          out_row_reg, out_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            rms_reg     <= root_reg[SAMPLE_BITS-1:0];
            out_row_reg <= pos_row_reg;
            out_col_reg <= pos_col_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_rms_level = rms_reg;
    assign m_grid_row  = out_row_reg;
    assign m_grid_col  = out_col_reg;

    assign status.row_done   = sq_valid_reg && sq_last_reg;
    assign status.would_last = would_last;
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule
